// ----- hw/rtl/mlqs_pkg.sv -----
package mlqs_pkg;

	localparam int MAX_JOBS = 64;
	localparam int IDX_W    = $clog2(MAX_JOBS);
	localparam int CNT_W    = IDX_W + 1;
	localparam int TIME_W   = 16;
	localparam int CLK_W    = 23;
	localparam int CLS_W    = 2;
	localparam int QNT_W    = 8;

	localparam logic [QNT_W-1:0] QUANTUM_RESET = QNT_W'(2);
	localparam logic [CLS_W-1:0] CLS_SYSTEM    = CLS_W'(1);
	localparam logic [CLS_W-1:0] CLS_INTERACT  = CLS_W'(2);

	// Queue select codes.
	localparam logic [1:0] Q_SYS = 2'd0;
	localparam logic [1:0] Q_INT = 2'd1;
	localparam logic [1:0] Q_BAT = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] burst_time;
		logic [CLS_W-1:0]  job_class;
		logic              last_job;
	} job_in_t;

	typedef struct packed {
		logic [5:0]       job_index;
		logic [CLK_W-1:0] completion_time;
		logic [CLK_W-1:0] turnaround_time;
		logic [CLK_W-1:0] waiting_time;
		logic             last_result;
	} res_out_t;

	typedef struct packed {
		logic       load_wr;
		logic       scan_start;
		logic       scan_eval;
		logic       rd_job;
		logic       pop;
		logic [1:0] pop_sel;
		logic       run_full;
		logic       run_slice;
		logic       rr_end;
		logic       idle_jump;
		logic       out_load;
		logic       out_next;
		logic       clear;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic all_done;
		logic sys_ne;
		logic int_ne;
		logic bat_ne;
	} dp_stat_t;

endpackage

// ----- hw/rtl/multilevel_queue_scheduler.sv -----
// Multilevel queue scheduler.
// The job channel (job_valid, job_stall, job) takes one word per cycle while
// the block is loading; each word is one job with its arrival, burst and class.
// A word with last_job set closes the set and starts the scheduling run, during
// which job_stall stays high. System jobs run to completion first, interactive
// jobs share the time slice written on cfg_we/cfg_data, and batch jobs run last.
// Each dispatch makes one or two admission scans over the N loaded jobs, and
// each scan reads the single-port job tables one job at a time.
// Results leave on the result channel (res_valid, res_stall, res), one word per
// job in load order; the last carries last_result.
// While res_stall is high the current result word is held unchanged.
// After the final result the tables are released and loading resumes.
// Reset empties all queues, clears the counters and the clock, and sets the
// time slice to 2; the job tables hold no value until they are written.
module multilevel_queue_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_stall,
	input  mlqs_pkg::job_in_t           job,
	output logic                        res_valid,
	input  logic                        res_stall,
	output mlqs_pkg::res_out_t          res,
	input  logic                        cfg_we,
	input  logic [mlqs_pkg::QNT_W-1:0]  cfg_data
);
	import mlqs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller sequences loading, scans, dispatch and result delivery.
	mlqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_last  (job.last_job),
		.job_stall (job_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the job tables, the three queues and the clock.
	mlqs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.res      (res)
	);

endmodule

// ----- hw/rtl/mlqs_ctrl.sv -----
module mlqs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  logic              job_last,
	output logic              job_stall,
	output logic              res_valid,
	input  logic              res_stall,
	input  mlqs_pkg::dp_stat_t stat,
	output mlqs_pkg::dp_cmd_t  cmd
);
	import mlqs_pkg::*;

	localparam logic [3:0] S_LOAD     = 4'd0;
	localparam logic [3:0] S_TOP      = 4'd1;
	localparam logic [3:0] S_ADM_RD   = 4'd2;
	localparam logic [3:0] S_ADM_EV   = 4'd3;
	localparam logic [3:0] S_PICK     = 4'd4;
	localparam logic [3:0] S_RUN_RD   = 4'd5;
	localparam logic [3:0] S_RUN_EX   = 4'd6;
	localparam logic [3:0] S_RR_RD    = 4'd7;
	localparam logic [3:0] S_RR_EX    = 4'd8;
	localparam logic [3:0] S_RR_END   = 4'd9;
	localparam logic [3:0] S_OUT_RD   = 4'd10;
	localparam logic [3:0] S_OUT_CALC = 4'd11;
	localparam logic [3:0] S_OUT_SEND = 4'd12;

	logic [3:0] state_q, state_d;
	logic       ret_rr_q, ret_rr_d;

	assign job_stall = (state_q != S_LOAD);
	assign res_valid = (state_q == S_OUT_SEND);

	always_comb begin
		state_d  = state_q;
		ret_rr_d = ret_rr_q;
		cmd      = '0;
		cmd.pop_sel = Q_SYS;
		unique case (state_q)
			S_LOAD: begin
				if (job_valid) begin
					cmd.load_wr = 1'b1;
					if (job_last) state_d = S_TOP;
				end
			end
			S_TOP: begin
				cmd.scan_start = 1'b1;
				ret_rr_d       = 1'b0;
				state_d        = stat.all_done ? S_OUT_RD : S_ADM_RD;
			end
			S_ADM_RD: begin
				if (stat.scan_done) state_d = ret_rr_q ? S_RR_END : S_PICK;
				else state_d = S_ADM_EV;
			end
			S_ADM_EV: begin
				cmd.scan_eval = 1'b1;
				state_d       = S_ADM_RD;
			end
			S_PICK: begin
				priority if (stat.sys_ne) begin
					cmd.pop = 1'b1; cmd.pop_sel = Q_SYS; state_d = S_RUN_RD;
				end else if (stat.int_ne) begin
					cmd.pop = 1'b1; cmd.pop_sel = Q_INT; state_d = S_RR_RD;
				end else if (stat.bat_ne) begin
					cmd.pop = 1'b1; cmd.pop_sel = Q_BAT; state_d = S_RUN_RD;
				end else begin
					cmd.idle_jump = 1'b1; state_d = S_TOP;
				end
			end
			S_RUN_RD: begin
				cmd.rd_job = 1'b1;
				state_d    = S_RUN_EX;
			end
			S_RUN_EX: begin
				cmd.run_full = 1'b1;
				state_d      = S_TOP;
			end
			S_RR_RD: begin
				cmd.rd_job = 1'b1;
				state_d    = S_RR_EX;
			end
			S_RR_EX: begin
				cmd.run_slice  = 1'b1;
				cmd.scan_start = 1'b1;
				ret_rr_d       = 1'b1;
				state_d        = S_ADM_RD;
			end
			S_RR_END: begin
				cmd.rr_end = 1'b1;
				state_d    = S_TOP;
			end
			S_OUT_RD: begin
				if (stat.scan_done) begin
					cmd.clear = 1'b1;
					state_d   = S_LOAD;
				end else begin
					state_d = S_OUT_CALC;
				end
			end
			S_OUT_CALC: begin
				cmd.out_load = 1'b1;
				state_d      = S_OUT_SEND;
			end
			S_OUT_SEND: begin
				if (!res_stall) begin
					cmd.out_next = 1'b1;
					state_d      = S_OUT_RD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			ret_rr_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_rr_q <= ret_rr_d;
		end
	end

endmodule

// ----- hw/rtl/mlqs_dp.sv -----
module mlqs_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mlqs_pkg::job_in_t       job,
	input  logic                    cfg_we,
	input  logic [mlqs_pkg::QNT_W-1:0] cfg_data,
	input  mlqs_pkg::dp_cmd_t       cmd,
	output mlqs_pkg::dp_stat_t      stat,
	output mlqs_pkg::res_out_t      res
);
	import mlqs_pkg::*;

	// Job tables.
	logic [TIME_W-1:0] arr_mem [MAX_JOBS];
	logic [TIME_W-1:0] bst_mem [MAX_JOBS];
	logic [TIME_W-1:0] rem_mem [MAX_JOBS];
	logic [CLS_W-1:0]  cls_mem [MAX_JOBS];
	logic [CLK_W-1:0]  fin_mem [MAX_JOBS];
	// Ready queues.
	logic [IDX_W-1:0]  sys_mem [MAX_JOBS];
	logic [IDX_W-1:0]  int_mem [MAX_JOBS];
	logic [IDX_W-1:0]  bat_mem [MAX_JOBS];

	logic [MAX_JOBS-1:0] adm_q;
	logic [QNT_W-1:0]    quantum_q;
	logic [CLK_W-1:0]    clock_q;
	logic [CNT_W-1:0]    loaded_q, done_q, scan_q;
	logic [TIME_W-1:0]   min_arr_q;
	logic                found_q;
	logic [IDX_W-1:0]    sys_head_q, int_head_q, bat_head_q;
	logic [CNT_W-1:0]    sys_cnt_q, int_cnt_q, bat_cnt_q;
	logic [IDX_W-1:0]    fifo_q;
	logic [TIME_W-1:0]   new_rem_q;

	logic [TIME_W-1:0] rd_arr_q, rd_bst_q, rd_rem_q;
	logic [CLS_W-1:0]  rd_cls_q;
	logic [CLK_W-1:0]  rd_fin_q;

	logic [IDX_W-1:0]  rd_addr, scan_idx, load_idx;
	logic              load_ok, elig, admit;
	logic              push_sys, push_int, push_bat;
	logic [IDX_W-1:0]  push_val;
	logic [TIME_W-1:0] q_eff, run_len;
	logic [CLK_W-1:0]  full_end, tat;

	assign scan_idx = scan_q[IDX_W-1:0];
	assign load_idx = loaded_q[IDX_W-1:0];
	assign rd_addr  = cmd.rd_job ? fifo_q : scan_idx;
	assign load_ok  = cmd.load_wr && (loaded_q < CNT_W'(MAX_JOBS));

	assign elig  = !adm_q[scan_idx] && (rd_rem_q != '0);
	assign admit = cmd.scan_eval && elig && ({{(CLK_W-TIME_W){1'b0}}, rd_arr_q} <= clock_q);

	assign q_eff    = (quantum_q == '0) ? TIME_W'(1) : TIME_W'(quantum_q);
	assign run_len  = (rd_rem_q < q_eff) ? rd_rem_q : q_eff;
	assign full_end = clock_q + CLK_W'(rd_rem_q);
	assign tat      = rd_fin_q - CLK_W'(rd_arr_q);

	always_comb begin
		push_sys = 1'b0;
		push_int = 1'b0;
		push_bat = 1'b0;
		push_val = scan_idx;
		if (admit) begin
			if (rd_cls_q == CLS_SYSTEM) push_sys = 1'b1;
			else if (rd_cls_q == CLS_INTERACT) push_int = 1'b1;
			else push_bat = 1'b1;
		end else if (cmd.rr_end && new_rem_q != '0) begin
			push_int = 1'b1;
			push_val = fifo_q;
		end
	end

	assign stat.scan_done = (scan_q == loaded_q);
	assign stat.all_done  = (done_q >= loaded_q);
	assign stat.sys_ne    = (sys_cnt_q != '0);
	assign stat.int_ne    = (int_cnt_q != '0);
	assign stat.bat_ne    = (bat_cnt_q != '0);

	// Table and queue storage.
	always_ff @(posedge clk) begin
		rd_arr_q <= arr_mem[rd_addr];
		rd_bst_q <= bst_mem[rd_addr];
		rd_rem_q <= rem_mem[rd_addr];
		rd_cls_q <= cls_mem[rd_addr];
		rd_fin_q <= fin_mem[rd_addr];
		if (load_ok) begin
			arr_mem[load_idx] <= job.arrival_time;
			bst_mem[load_idx] <= job.burst_time;
			cls_mem[load_idx] <= job.job_class;
		end
		if (load_ok) rem_mem[load_idx] <= job.burst_time;
		else if (cmd.run_full) rem_mem[fifo_q] <= '0;
		else if (cmd.run_slice) rem_mem[fifo_q] <= rd_rem_q - run_len;
		if (load_ok) fin_mem[load_idx] <= CLK_W'(job.arrival_time);
		else if (cmd.run_full) fin_mem[fifo_q] <= full_end;
		else if (cmd.rr_end) fin_mem[fifo_q] <= clock_q;
		if (push_sys) sys_mem[sys_head_q + sys_cnt_q[IDX_W-1:0]] <= push_val;
		if (push_int) int_mem[int_head_q + int_cnt_q[IDX_W-1:0]] <= push_val;
		if (push_bat) bat_mem[bat_head_q + bat_cnt_q[IDX_W-1:0]] <= push_val;
		if (cmd.pop) begin
			unique case (cmd.pop_sel)
				Q_SYS:   fifo_q <= sys_mem[sys_head_q];
				Q_INT:   fifo_q <= int_mem[int_head_q];
				default: fifo_q <= bat_mem[bat_head_q];
			endcase
		end
		if (cmd.run_slice) new_rem_q <= rd_rem_q - run_len;
		if (cmd.out_load) begin
			res.job_index       <= 6'(scan_q);
			res.completion_time <= rd_fin_q;
			res.turnaround_time <= tat;
			res.waiting_time    <= tat - CLK_W'(rd_bst_q);
			res.last_result     <= (scan_q + CNT_W'(1) == loaded_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q  <= QUANTUM_RESET;
			adm_q      <= '0;
			clock_q    <= '0;
			loaded_q   <= '0;
			done_q     <= '0;
			scan_q     <= '0;
			min_arr_q  <= '0;
			found_q    <= 1'b0;
			sys_head_q <= '0;
			int_head_q <= '0;
			bat_head_q <= '0;
			sys_cnt_q  <= '0;
			int_cnt_q  <= '0;
			bat_cnt_q  <= '0;
		end else begin
			if (cfg_we) quantum_q <= cfg_data;
			if (cmd.clear) begin
				adm_q      <= '0;
				clock_q    <= '0;
				loaded_q   <= '0;
				done_q     <= '0;
				sys_head_q <= '0;
				int_head_q <= '0;
				bat_head_q <= '0;
				sys_cnt_q  <= '0;
				int_cnt_q  <= '0;
				bat_cnt_q  <= '0;
			end else begin
				if (load_ok) begin
					adm_q[load_idx] <= (job.burst_time == '0);
					loaded_q        <= loaded_q + CNT_W'(1);
					if (job.burst_time == '0) done_q <= done_q + CNT_W'(1);
				end
				if (cmd.scan_start) begin
					scan_q  <= '0;
					found_q <= 1'b0;
				end
				if (cmd.scan_eval) begin
					scan_q <= scan_q + CNT_W'(1);
					if (admit) begin
						adm_q[scan_idx] <= 1'b1;
					end else if (elig && (!found_q || rd_arr_q < min_arr_q)) begin
						min_arr_q <= rd_arr_q;
						found_q   <= 1'b1;
					end
				end
				if (cmd.out_next) scan_q <= scan_q + CNT_W'(1);
				if (cmd.idle_jump && found_q) clock_q <= CLK_W'(min_arr_q);
				if (cmd.run_full) begin
					clock_q <= full_end;
					done_q  <= done_q + CNT_W'(1);
				end
				if (cmd.run_slice) clock_q <= clock_q + CLK_W'(run_len);
				if (cmd.rr_end && new_rem_q == '0) done_q <= done_q + CNT_W'(1);
				if (cmd.pop) begin
					unique case (cmd.pop_sel)
						Q_SYS: begin
							sys_head_q <= sys_head_q + IDX_W'(1);
							sys_cnt_q  <= sys_cnt_q - CNT_W'(1);
						end
						Q_INT: begin
							int_head_q <= int_head_q + IDX_W'(1);
							int_cnt_q  <= int_cnt_q - CNT_W'(1);
						end
						default: begin
							bat_head_q <= bat_head_q + IDX_W'(1);
							bat_cnt_q  <= bat_cnt_q - CNT_W'(1);
						end
					endcase
				end
				if (push_sys) sys_cnt_q <= sys_cnt_q + CNT_W'(1);
				if (push_int) int_cnt_q <= int_cnt_q + CNT_W'(1);
				if (push_bat) bat_cnt_q <= bat_cnt_q + CNT_W'(1);
			end
		end
	end

endmodule
